// ===== design/radix_digit_serial_arithmetic_unit_defines.svh =====
// Assertion helpers used by the top design file, radix_digit_serial_arithmetic_unit.sv.
// Each macro expects clk and rst_n in scope.
`ifndef RADIX_DIGIT_SERIAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RADIX_DIGIT_SERIAL_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication
`define RDSA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RDSA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rdsa_pkg.sv =====
`default_nettype none

package rdsa_pkg;

    localparam int DIGIT_BITS_DEF  = 4;
    localparam int RADIX_W         = 5;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    // quotient bits retired per divider cycle
    localparam int QBITS_PER_CYCLE = 2;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_BAD_DIGIT,
        STAT_NEG,
        STAT_DIV0
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_OUT1,
        ST_OUT2
    } state_t;

endpackage

`default_nettype wire

// ===== design/radix_digit_serial_arithmetic_unit.sv =====
// Digit-serial add, subtract, multiply-by-digit and divide-by-digit in a base
// of 2 to 2^DIGIT_BITS, set by cfg_wr_data (clamped); the user must see that it is
// written only while idle, as the block itself does not enforce this. Each digit
// item passes from acceptance through the operand stage (one multiply and add),
// the shared restoring divider that retires two quotient bits per cycle and
// produces every digit and carry, the hand-over of the divider's done flag and
// the load of the result into the output register. The next item can be accepted
// in the cycle after the load. A final carry digit of add or multiply takes one
// more output slot. The output register lets the next item be accepted while a
// result still waits on m_axis_tready; tready stays low from acceptance until the
// item's last result is loaded, including any wait for the output register to be
// taken.
`default_nettype none
`include "radix_digit_serial_arithmetic_unit_defines.svh"

module radix_digit_serial_arithmetic_unit #(
    parameter int DIGIT_BITS = rdsa_pkg::DIGIT_BITS_DEF,
    localparam int IN_TDATA_W  = ((2*DIGIT_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((2*DIGIT_BITS + 7) / 8) * 8
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_wr_en,
    input  wire [rdsa_pkg::RADIX_W-1:0]  cfg_wr_data,   // radix
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire [IN_TDATA_W-1:0]         s_axis_tdata,  // digit_a, digit_b
    input  wire [1:0]                    s_axis_tuser,  // op
    input  wire                          s_axis_tlast,  // last_digit
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [OUT_TDATA_W-1:0]       m_axis_tdata,  // result_digit, remainder
    output logic [1:0]                   m_axis_tuser,  // status
    output logic                         m_axis_tlast   // end_of_result
);

    localparam int W  = DIGIT_BITS;
    localparam int DW = 2*W + 2;
    localparam int CW = (W + 1 > rdsa_pkg::RADIX_W) ? W + 1 : rdsa_pkg::RADIX_W;

    rdsa_pkg::state_t  state_reg, state_next;
    rdsa_pkg::op_t     op_reg;
    logic [W-1:0]      a_reg;
    logic [W-1:0]      b_reg;
    logic              last_reg;
    logic [rdsa_pkg::RADIX_W-1:0] radix_reg;

    logic [W-1:0]      carry_reg, carry_next;
    logic              borrow_reg, borrow_next;
    logic              qs_reg, qs_next;
    rdsa_pkg::status_t err_reg, err_next;
    rdsa_pkg::status_t st_reg, st_next;

    logic              out_valid_reg, out_valid_next;
    logic [W-1:0]      out_digit_reg, out_digit_next;
    logic [W-1:0]      out_rem_reg, out_rem_next;
    logic [1:0]        out_st_reg, out_st_next;
    logic              out_end_reg, out_end_next;
    logic              out_load;

    logic              in_accept;
    logic              out_free;

    logic [CW-1:0]     radix_ext;
    logic [CW-1:0]     radix_top;
    logic [W:0]        radix_eff;
    rdsa_pkg::status_t err_item;

    logic [DW-1:0]     dividend;
    logic [W:0]        divisor;
    logic              div_start;
    logic              div_busy;
    logic              div_done;
    logic [DW-1:0]     quot;
    logic [W:0]        rem;

    // first result of the item and the state it leaves
    logic [W-1:0]      r1_digit;
    logic [W-1:0]      r1_rem;
    rdsa_pkg::status_t r1_status;
    logic              r1_end;
    logic              r1_emit;
    logic              r1_second;
    logic [W-1:0]      carry_upd;
    logic              borrow_upd;
    logic              qs_upd;
    logic [W-1:0]      r2_digit;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == rdsa_pkg::ST_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign radix_ext = CW'(radix_reg);
    assign radix_top = CW'(1) << W;
    assign radix_eff = (radix_ext < CW'(2))    ? (W+1)'(2) :
                       (radix_ext > radix_top) ? radix_top[W:0] : radix_ext[W:0];

    always_comb
    begin
        err_item = err_reg;
        if (err_reg == rdsa_pkg::STAT_OK)
        begin
            if (({1'b0, a_reg} >= radix_eff) || ({1'b0, b_reg} >= radix_eff))
            begin
                err_item = rdsa_pkg::STAT_BAD_DIGIT;
            end
            else if ((op_reg == rdsa_pkg::OP_DIV) && (b_reg == '0))
            begin
                err_item = rdsa_pkg::STAT_DIV0;
            end
        end
    end

    rdsa_operand #(
        .DIGIT_BITS (DIGIT_BITS)
    ) u_operand (
        .op        (op_reg),
        .digit_a   (a_reg),
        .digit_b   (b_reg),
        .carry     (carry_reg),
        .borrow    (borrow_reg),
        .radix_eff (radix_eff),
        .dividend  (dividend),
        .divisor   (divisor)
    );

    rdsa_divider #(
        .DIGIT_BITS (DIGIT_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (quot),
        .rem      (rem)
    );

    always_comb
    begin
        logic carry_bit;
        logic [W-1:0] q_dig;
        r1_digit   = rem[W-1:0];
        r1_rem     = '0;
        r1_status  = st_reg;
        r1_end     = last_reg;
        r1_emit    = 1'b1;
        r1_second  = 1'b0;
        carry_upd  = carry_reg;
        borrow_upd = borrow_reg;
        qs_upd     = qs_reg;
        carry_bit  = |quot;
        q_dig      = quot[W-1:0];
        case (op_reg)
            rdsa_pkg::OP_ADD:
            begin
                carry_upd = W'(carry_bit);
                r1_end    = last_reg && !carry_bit;
                r1_second = last_reg && carry_bit;
            end
            rdsa_pkg::OP_SUB:
            begin
                borrow_upd = ({1'b0, a_reg} < ({1'b0, b_reg} + (W+1)'(borrow_reg)));
                if (last_reg && (st_reg == rdsa_pkg::STAT_OK) && borrow_upd)
                begin
                    r1_status = rdsa_pkg::STAT_NEG;
                end
            end
            rdsa_pkg::OP_MUL:
            begin
                carry_upd = q_dig;
                r1_end    = last_reg && (q_dig == '0);
                r1_second = last_reg && (q_dig != '0);
            end
            rdsa_pkg::OP_DIV:
            begin
                if (b_reg == '0)
                begin
                    q_dig     = '0;
                    carry_upd = '0;
                end
                else
                begin
                    carry_upd = rem[W-1:0];
                end
                r1_digit = q_dig;
                qs_upd   = qs_reg || (q_dig != '0);
                r1_emit  = last_reg || qs_upd;
                r1_rem   = last_reg ? carry_upd : '0;
            end
            default:
            begin
                r1_emit = 1'b1;
            end
        endcase
    end

    assign r2_digit = (op_reg == rdsa_pkg::OP_ADD) ? W'(1) : quot[W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        carry_next     = carry_reg;
        borrow_next    = borrow_reg;
        qs_next        = qs_reg;
        err_next       = err_reg;
        st_next        = st_reg;
        div_start      = 1'b0;
        out_load       = 1'b0;
        out_digit_next = out_digit_reg;
        out_rem_next   = out_rem_reg;
        out_st_next    = out_st_reg;
        out_end_next   = out_end_reg;
        case (state_reg)
            rdsa_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = rdsa_pkg::ST_LOAD;
                end
            end
            rdsa_pkg::ST_LOAD:
            begin
                div_start  = 1'b1;
                err_next   = err_item;
                st_next    = err_item;
                state_next = rdsa_pkg::ST_RUN;
            end
            rdsa_pkg::ST_RUN:
            begin
                if (div_done)
                begin
                    state_next = rdsa_pkg::ST_OUT1;
                end
            end
            rdsa_pkg::ST_OUT1:
            begin
                if (out_free)
                begin
                    out_load       = r1_emit;
                    out_digit_next = r1_digit;
                    out_rem_next   = r1_rem;
                    out_st_next    = r1_status;
                    out_end_next   = r1_end;
                    if (last_reg)
                    begin
                        carry_next  = '0;
                        borrow_next = 1'b0;
                        qs_next     = 1'b0;
                        err_next    = rdsa_pkg::STAT_OK;
                    end
                    else
                    begin
                        carry_next  = carry_upd;
                        borrow_next = borrow_upd;
                        qs_next     = qs_upd;
                    end
                    state_next = r1_second ? rdsa_pkg::ST_OUT2 : rdsa_pkg::ST_IDLE;
                end
            end
            rdsa_pkg::ST_OUT2:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_digit_next = r2_digit;
                    out_rem_next   = '0;
                    out_st_next    = st_reg;
                    out_end_next   = 1'b1;
                    state_next     = rdsa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rdsa_pkg::ST_IDLE;
            end
        endcase
        out_valid_next = out_load || (out_valid_reg && !m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rdsa_pkg::ST_IDLE;
            radix_reg     <= rdsa_pkg::RADIX_RESET;
            carry_reg     <= '0;
            borrow_reg    <= 1'b0;
            qs_reg        <= 1'b0;
            err_reg       <= rdsa_pkg::STAT_OK;
            st_reg        <= rdsa_pkg::STAT_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            carry_reg     <= carry_next;
            borrow_reg    <= borrow_next;
            qs_reg        <= qs_next;
            err_reg       <= err_next;
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                radix_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg   <= rdsa_pkg::op_t'(s_axis_tuser);
            a_reg    <= s_axis_tdata[W-1:0];
            b_reg    <= s_axis_tdata[2*W-1:W];
            last_reg <= s_axis_tlast;
        end
        out_digit_reg <= out_digit_next;
        out_rem_reg   <= out_rem_next;
        out_st_reg    <= out_st_next;
        out_end_reg   <= out_end_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_rem_reg, out_digit_reg});
    assign m_axis_tuser  = out_st_reg;
    assign m_axis_tlast  = out_end_reg;

    `RDSA_ASSERT_IMP(a_ready_div_idle, s_axis_tready, !div_busy, "item accepted while divider busy")
    `RDSA_ASSERT_NXT(a_load_starts_div, state_reg == rdsa_pkg::ST_LOAD, div_busy, "divider not started")
    `RDSA_ASSERT_IMP(a_done_in_run, div_done, state_reg == rdsa_pkg::ST_RUN, "divider done outside run")
    `RDSA_ASSERT_IMP(a_carry_op, state_reg == rdsa_pkg::ST_OUT2, (op_reg == rdsa_pkg::OP_ADD) || (op_reg == rdsa_pkg::OP_MUL), "carry digit for wrong op")

endmodule

`default_nettype wire

// ===== design/rdsa_operand.sv =====
`default_nettype none

// Forms the dividend and divisor for the shared divider from one digit item.
module rdsa_operand #(
    parameter int DIGIT_BITS = rdsa_pkg::DIGIT_BITS_DEF
) (
    input  wire rdsa_pkg::op_t         op,
    input  wire [DIGIT_BITS-1:0]       digit_a,
    input  wire [DIGIT_BITS-1:0]       digit_b,
    input  wire [DIGIT_BITS-1:0]       carry,
    input  wire                        borrow,
    input  wire [DIGIT_BITS:0]         radix_eff,
    output logic [2*DIGIT_BITS+1:0]    dividend,
    output logic [DIGIT_BITS:0]        divisor
);

    localparam int DW = 2*DIGIT_BITS + 2;
    localparam int AW = DIGIT_BITS + 2;

    logic [DIGIT_BITS:0] mul_x;
    logic [DIGIT_BITS:0] mul_y;
    logic [AW-1:0]       add_term;
    logic [AW-1:0]       sub_term;
    logic [DW-1:0]       product;

    always_comb
    begin
        mul_x    = '0;
        mul_y    = '0;
        add_term = '0;
        sub_term = '0;
        case (op)
            rdsa_pkg::OP_ADD:
            begin
                add_term = AW'(carry) + AW'(digit_a) + AW'(digit_b);
            end
            rdsa_pkg::OP_SUB:
            begin
                // a - b - borrow + r*(2^W + 1) keeps the value positive
                mul_x    = radix_eff;
                mul_y    = {1'b1, {(DIGIT_BITS-1){1'b0}}, 1'b1};
                add_term = AW'(digit_a);
                sub_term = AW'(digit_b) + AW'(borrow);
            end
            rdsa_pkg::OP_MUL:
            begin
                mul_x    = {1'b0, digit_a};
                mul_y    = {1'b0, digit_b};
                add_term = AW'(carry);
            end
            rdsa_pkg::OP_DIV:
            begin
                mul_x    = radix_eff;
                mul_y    = {1'b0, carry};
                add_term = AW'(digit_a);
            end
            default:
            begin
                mul_x = '0;
            end
        endcase
    end

    assign product  = DW'(mul_x) * DW'(mul_y);
    assign dividend = product + DW'(add_term) - DW'(sub_term);
    assign divisor  = (op == rdsa_pkg::OP_DIV) ? {1'b0, digit_b} : radix_eff;

endmodule

`default_nettype wire

// ===== design/rdsa_divider.sv =====
`default_nettype none

// Restoring divider, two quotient bits per cycle.
// Quotient ends up in quot, remainder in rem; done pulses once when both hold.
module rdsa_divider #(
    parameter int DIGIT_BITS = rdsa_pkg::DIGIT_BITS_DEF
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      start,
    input  wire [2*DIGIT_BITS+1:0]   dividend,
    input  wire [DIGIT_BITS:0]       divisor,
    output logic                     busy,
    output logic                     done,
    output logic [2*DIGIT_BITS+1:0]  quot,
    output logic [DIGIT_BITS:0]      rem
);

    localparam int DW    = 2*DIGIT_BITS + 2;
    localparam int STEPS = DW / rdsa_pkg::QBITS_PER_CYCLE;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [DW-1:0]         n_reg;
    logic [DIGIT_BITS:0]   p_reg;
    logic [DIGIT_BITS:0]   d_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DW-1:0]         n_next;
    logic [DIGIT_BITS:0]   p_next;

    always_comb
    begin
        logic [DIGIT_BITS+1:0] pw;
        n_next = n_reg;
        p_next = p_reg;
        for (int i = 0; i < rdsa_pkg::QBITS_PER_CYCLE; i++)
        begin
            pw     = {p_next, n_next[DW-1]};
            n_next = {n_next[DW-2:0], 1'b0};
            if (pw >= {1'b0, d_reg})
            begin
                pw        = pw - {1'b0, d_reg};
                n_next[0] = 1'b1;
            end
            p_next = pw[DIGIT_BITS:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(STEPS-1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg <= dividend;
            p_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            n_reg <= n_next;
            p_reg <= p_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = n_reg;
    assign rem  = p_reg;

endmodule

`default_nettype wire

// ===== tb/radix_digit_serial_arithmetic_unit_test.sv =====
`timescale 1ns / 100ps

module radix_digit_serial_arithmetic_unit_test;
    import rdsa_pkg::*;

    localparam int DIGIT_BITS    = DIGIT_BITS_DEF;
    localparam int DIGIT_MASK    = (1 << DIGIT_BITS) - 1;
    localparam int MAX_GAP       = 11;
    localparam int SETTLE_CYCLES = 24;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PREDICTED     = -1;
    localparam int NUM_DIRECTED  = 23;
    localparam int PHASE_ITEMS   = 110;

    typedef struct packed {
        logic [3:0] digit;
        logic [3:0] rem;
        status_t    st;
        logic       eor;
    } digit_result_t;

    typedef struct {
        op_t           op;
        logic [3:0]    a;
        logic [3:0]    b;
        logic          last;
        int            n_typed;
        digit_result_t r0;
        digit_result_t r1;
    } directed_row_t;

    localparam digit_result_t NO_RES = '{4'd0, 4'd0, STAT_OK, 1'b0};

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [RADIX_W-1:0]   cfg_wr_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;   // digit_a, digit_b
    logic [1:0]           s_axis_tuser;   // op
    logic                 s_axis_tlast;   // last_digit
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [7:0]           m_axis_tdata;   // result_digit, remainder
    logic [1:0]           m_axis_tuser;   // status
    logic                 m_axis_tlast;   // end_of_result

    // predictor state
    logic [RADIX_W-1:0]   model_radix;
    int                   carry_rem;
    bit                   borrow;
    bit                   q_started;
    status_t              err_code;

    digit_result_t        pending_digits[$];
    int                   mismatches;
    int                   quiet_cycles;
    bit                   burst;

    directed_row_t directed_rows [NUM_DIRECTED] = '{
        '{OP_ADD, 4'd9,  4'd9,  1'b1, 2, '{4'd8, 4'd0, STAT_OK, 1'b0},
                                         '{4'd1, 4'd0, STAT_OK, 1'b1}},
        '{OP_ADD, 4'd15, 4'd0,  1'b1, 2, '{4'd5, 4'd0, STAT_BAD_DIGIT, 1'b0},
                                         '{4'd1, 4'd0, STAT_BAD_DIGIT, 1'b1}},
        '{OP_SUB, 4'd0,  4'd9,  1'b1, 1, '{4'd1, 4'd0, STAT_NEG, 1'b1}, NO_RES},
        '{OP_SUB, 4'd15, 4'd15, 1'b1, 1, '{4'd0, 4'd0, STAT_BAD_DIGIT, 1'b1}, NO_RES},
        '{OP_MUL, 4'd9,  4'd9,  1'b1, 2, '{4'd1, 4'd0, STAT_OK, 1'b0},
                                         '{4'd8, 4'd0, STAT_OK, 1'b1}},
        '{OP_DIV, 4'd9,  4'd2,  1'b1, 1, '{4'd4, 4'd1, STAT_OK, 1'b1}, NO_RES},
        '{OP_DIV, 4'd7,  4'd0,  1'b1, 1, '{4'd0, 4'd0, STAT_DIV0, 1'b1}, NO_RES},
        // bad digit wins over zero divisor
        '{OP_DIV, 4'd11, 4'd0,  1'b1, 1, '{4'd0, 4'd0, STAT_BAD_DIGIT, 1'b1}, NO_RES},
        // leading quotient zeros suppressed
        '{OP_DIV, 4'd0,  4'd3,  1'b0, PREDICTED, NO_RES, NO_RES},
        '{OP_DIV, 4'd1,  4'd3,  1'b0, PREDICTED, NO_RES, NO_RES},
        '{OP_DIV, 4'd2,  4'd3,  1'b1, PREDICTED, NO_RES, NO_RES},
        '{OP_ADD, 4'd9,  4'd9,  1'b0, PREDICTED, NO_RES, NO_RES},
        '{OP_ADD, 4'd0,  4'd0,  1'b1, PREDICTED, NO_RES, NO_RES},
        '{OP_SUB, 4'd3,  4'd5,  1'b0, PREDICTED, NO_RES, NO_RES},
        '{OP_SUB, 4'd7,  4'd1,  1'b1, PREDICTED, NO_RES, NO_RES},
        // multiply carry wraps with invalid digits
        '{OP_MUL, 4'd15, 4'd15, 1'b0, PREDICTED, NO_RES, NO_RES},
        '{OP_MUL, 4'd15, 4'd15, 1'b1, PREDICTED, NO_RES, NO_RES},
        // sticky error on later digits
        '{OP_ADD, 4'd12, 4'd1,  1'b0, PREDICTED, NO_RES, NO_RES},
        '{OP_ADD, 4'd1,  4'd1,  1'b1, PREDICTED, NO_RES, NO_RES},
        '{OP_DIV, 4'd0,  4'd0,  1'b0, PREDICTED, NO_RES, NO_RES},
        '{OP_DIV, 4'd12, 4'd4,  1'b1, PREDICTED, NO_RES, NO_RES},
        // mixed ops within one number
        '{OP_ADD, 4'd4,  4'd4,  1'b0, PREDICTED, NO_RES, NO_RES},
        '{OP_MUL, 4'd3,  4'd3,  1'b1, PREDICTED, NO_RES, NO_RES}
    };

    radix_digit_serial_arithmetic_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic int clamp_radix(input logic [RADIX_W-1:0] v);
        if (v < 2)
            return 2;
        if (v > DIGIT_MASK + 1)
            return DIGIT_MASK + 1;
        return int'(v);
    endfunction

    function automatic void clear_number_state();
        carry_rem = 0;
        borrow    = 1'b0;
        q_started = 1'b0;
        err_code  = STAT_OK;
    endfunction

    // Advances the digit state by one item and returns how many result digits it gives.
    function automatic int next_result_digits(input op_t op, input logic [3:0] a, b,
                                              input logic last,
                                              output digit_result_t r0, r1);
        int      r;
        int      ai;
        int      bi;
        int      val;
        int      q;
        int      n;
        status_t st;
        r  = clamp_radix(model_radix);
        ai = int'(a);
        bi = int'(b);
        n  = 0;
        r0 = NO_RES;
        r1 = NO_RES;
        if (err_code == STAT_OK && (ai >= r || bi >= r))
            err_code = STAT_BAD_DIGIT;
        if (err_code == STAT_OK && op == OP_DIV && bi == 0)
            err_code = STAT_DIV0;
        st = err_code;
        case (op)
            OP_ADD, OP_MUL:
            begin
                val = (op == OP_ADD) ? carry_rem + ai + bi : carry_rem + ai * bi;
                if (op == OP_ADD)
                    carry_rem = (val >= r) ? 1 : 0;
                else
                    carry_rem = (val / r) & DIGIT_MASK;
                r0 = '{4'(val % r), 4'd0, st, last && carry_rem == 0};
                n  = 1;
                if (last && carry_rem != 0)
                begin
                    r1 = '{4'(carry_rem), 4'd0, st, 1'b1};
                    n  = 2;
                end
            end
            OP_SUB:
            begin
                val    = ai + (DIGIT_MASK + 2) * r - bi - int'(borrow);
                borrow = (ai < bi + int'(borrow));
                if (last && st == STAT_OK && borrow)
                    st = STAT_NEG;
                r0 = '{4'(val % r), 4'd0, st, last};
                n  = 1;
            end
            default:
            begin
                if (bi == 0)
                begin
                    q         = 0;
                    carry_rem = 0;
                end
                else
                begin
                    val       = carry_rem * r + ai;
                    q         = (val / bi) & DIGIT_MASK;
                    carry_rem = (val % bi) & DIGIT_MASK;
                end
                if (q != 0)
                    q_started = 1'b1;
                if (last)
                begin
                    r0 = '{4'(q), 4'(carry_rem), st, 1'b1};
                    n  = 1;
                end
                else if (q_started)
                begin
                    r0 = '{4'(q), 4'd0, st, 1'b0};
                    n  = 1;
                end
            end
        endcase
        if (last)
            clear_number_state();
        return n;
    endfunction

    task automatic run_item(input op_t op, input logic [3:0] a, b, input logic last,
                            input int n_typed, input digit_result_t t0, t1);
        int            gap;
        int            n;
        digit_result_t p0;
        digit_result_t p1;
        gap = burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= op;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        n = next_result_digits(op, a, b, last, p0, p1);
        if (n_typed != PREDICTED)
        begin
            n  = n_typed;
            p0 = t0;
            p1 = t1;
        end
        if (n > 0)
            pending_digits.push_back(p0);
        if (n > 1)
            pending_digits.push_back(p1);
    endtask

    task automatic set_radix(input logic [RADIX_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_digits.size() != 0)
            @(posedge clk);
        // a divide item may still be in flight with no result
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        model_radix = v;
    endtask

    // One number: mostly well formed, some with bad digits or mixed ops.
    task automatic send_number(inout int count);
        int         r;
        int         len;
        int         kind;
        op_t        op;
        logic [3:0] a;
        logic [3:0] b;
        logic [3:0] b_fix;
        r     = clamp_radix(model_radix);
        burst = ($urandom_range(0, 7) == 0);
        kind  = $urandom_range(0, 9);
        len   = $urandom_range(1, 6);
        op    = op_t'($urandom_range(0, 3));
        b_fix = (op == OP_DIV) ? 4'($urandom_range(1, r - 1)) : 4'($urandom_range(0, r - 1));
        for (int k = 0; k < len; k++)
        begin
            if (kind == 9)
                op = op_t'($urandom_range(0, 3));
            a = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(0, r - 1));
            b = (op == OP_MUL || op == OP_DIV) ? b_fix : 4'($urandom_range(0, r - 1));
            if (kind == 8 && $urandom_range(0, len - 1) == 0)
            begin
                a = 4'($urandom_range(0, DIGIT_MASK));
                b = 4'($urandom_range(0, DIGIT_MASK));
            end
            run_item(op, a, b, k == len - 1, PREDICTED, NO_RES, NO_RES);
        end
        count += len;
    endtask

    always @(posedge clk)
    begin : check_results
        digit_result_t exp_res;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_digits.size() == 0)
            begin
                $error("unexpected result digit %0d", m_axis_tdata[3:0]);
                mismatches++;
            end
            else
            begin
                exp_res = pending_digits.pop_front();
                if (m_axis_tdata[3:0] !== exp_res.digit)
                begin
                    $error("result_digit: expected %0d, got %0d", exp_res.digit,
                           m_axis_tdata[3:0]);
                    mismatches++;
                end
                if (m_axis_tdata[7:4] !== exp_res.rem)
                begin
                    $error("remainder: expected %0d, got %0d", exp_res.rem,
                           m_axis_tdata[7:4]);
                    mismatches++;
                end
                if (m_axis_tuser !== exp_res.st)
                begin
                    $error("status: expected %0d, got %0d", exp_res.st, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tlast !== exp_res.eor)
                begin
                    $error("end_of_result: expected %0d, got %0d", exp_res.eor,
                           m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // result side backpressure
    initial
    begin : drain_results
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = burst ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    initial
    begin : stimulus
        int                 radix_plan [8];
        int                 count;
        logic [RADIX_W-1:0] v;
        radix_plan    = '{2, 16, 0, 31, 1, 7, 13, 10};
        mismatches    = 0;
        quiet_cycles  = 0;
        burst         = 1'b0;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        model_radix   = RADIX_RESET;
        clear_number_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            run_item(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                     directed_rows[i].last, directed_rows[i].n_typed,
                     directed_rows[i].r0, directed_rows[i].r1);

        for (int p = 0; p < 9; p++)
        begin
            v = (p < 8) ? RADIX_W'(radix_plan[p]) : RADIX_W'($urandom_range(0, 31));
            burst = 1'b0;
            set_radix(v);
            count = 0;
            while (count < PHASE_ITEMS)
                send_number(count);
        end

        s_axis_tvalid <= 1'b0;
        while (pending_digits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/rdsa_pkg.sv
design/rdsa_operand.sv
design/rdsa_divider.sv
design/radix_digit_serial_arithmetic_unit.sv
tb/radix_digit_serial_arithmetic_unit_test.sv
